// ===== rtl/note_off_scheduler_top_macros.svh =====
// Assertion macros shared by the note-off scheduler checker.
// Depends on nothing; included by the files that assert.
`ifndef NOTE_OFF_SCHEDULER_TOP_MACROS_SVH
`define NOTE_OFF_SCHEDULER_TOP_MACROS_SVH

// Antecedent in one cycle implies the consequent in the next cycle.
`define NOS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("nos: next-cycle property failed");

// Antecedent implies the consequent in the same cycle.
`define NOS_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("nos: same-cycle property failed");

`endif

// ===== rtl/nos_pkg.sv =====
// Shared types and constants of the note-off scheduler.
// Used by the datapath, the controller and the top level; depends on nothing.
package nos_pkg;

  localparam int MAX_PENDING = 16;
  localparam int TICK_W      = 16;
  localparam int DUR_W       = 16;
  localparam int CNT_W       = $clog2(MAX_PENDING + 1);
  localparam int IDX_W       = (MAX_PENDING > 1) ? $clog2(MAX_PENDING) : 1;

  typedef enum logic [1:0] {
    OP_NOTE  = 2'd0,
    OP_TICK  = 2'd1,
    OP_STOP  = 2'd2,
    OP_CLEAR = 2'd3
  } op_e;

  typedef struct packed {
    op_e              opcode;
    logic [6:0]       pitch;
    logic [6:0]       velocity;
    logic [DUR_W-1:0] duration_ticks;
  } item_t;

  typedef struct packed {
    logic [6:0] out_pitch;
    logic [6:0] out_velocity;
    logic       last;
  } result_t;

  // Datapath operations issued by the controller, one per cycle.
  typedef enum logic [3:0] {
    DP_NOP,
    DP_CAPTURE,
    DP_READ_OLDEST,
    DP_NOTE_OFF,
    DP_NOTE_ON,
    DP_TICK_START,
    DP_TICK_STEP,
    DP_TICK_END,
    DP_STOP_START,
    DP_STOP_STEP,
    DP_CLEAR
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
  } cmd_t;

  typedef struct packed {
    op_e  opcode;
    logic vel_zero;
    logic full;
    logic empty;
    logic more;
    logic at_zero;
  } stat_t;

endpackage

// ===== rtl/nos_datapath.sv =====
// Datapath of the note-off scheduler: pending-entry memory kept as a ring,
// index counters, held note-off and result register. Depends on nos_pkg.
module nos_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  nos_pkg::item_t  item_i,
  input  nos_pkg::cmd_t   cmd_i,
  output nos_pkg::stat_t  stat_o,
  output nos_pkg::result_t res_o,
  output logic            strobe_o
);
  import nos_pkg::*;

  typedef struct packed {
    logic [6:0]        pitch;
    logic [TICK_W-1:0] ticks;
  } pend_t;

  localparam logic [TICK_W-1:0] TICK_MAX = {TICK_W{1'b1}};

  pend_t mem [MAX_PENDING];

  item_t             item_q, item_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  rd_idx_q, rd_idx_d;
  logic [CNT_W-1:0]  keep_q, keep_d;
  logic              held_vld_q, held_vld_d;
  logic [6:0]        held_pitch_q, held_pitch_d;
  pend_t             rdata_q;
  result_t           res_q, res_d;
  logic              strobe_q, strobe_d;

  logic              rd_en, wr_en;
  logic [CNT_W-1:0]  rd_log, wr_log;
  pend_t             wr_data;
  logic [TICK_W-1:0] tick_dec;
  logic [TICK_W-1:0] dur_sat;

  // Logical position relative to the oldest entry, mapped onto the ring.
  function automatic logic [IDX_W-1:0] phys_idx(input logic [IDX_W-1:0] base,
                                                 input logic [CNT_W-1:0] ofs);
    logic [CNT_W:0] sum;
    sum = (CNT_W+1)'(base) + (CNT_W+1)'(ofs);
    if (sum >= (CNT_W+1)'(MAX_PENDING)) begin
      sum = sum - (CNT_W+1)'(MAX_PENDING);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign tick_dec = (rdata_q.ticks == '0) ? '0 : rdata_q.ticks - TICK_W'(1);

  always_comb begin
    if (33'(item_q.duration_ticks) > 33'(TICK_MAX)) begin
      dur_sat = TICK_MAX;
    end else begin
      dur_sat = TICK_W'(item_q.duration_ticks);
    end
  end

  always_comb begin
    item_d       = item_q;
    count_d      = count_q;
    head_d       = head_q;
    rd_idx_d     = rd_idx_q;
    keep_d       = keep_q;
    held_vld_d   = held_vld_q;
    held_pitch_d = held_pitch_q;
    res_d        = res_q;
    strobe_d     = 1'b0;
    rd_en        = 1'b0;
    rd_log       = '0;
    wr_en        = 1'b0;
    wr_log       = count_q;
    wr_data      = '{pitch: item_q.pitch, ticks: dur_sat};
    case (cmd_i.op)
      DP_CAPTURE: begin
        item_d = item_i;
      end
      DP_READ_OLDEST: begin
        rd_en = 1'b1;
      end
      DP_NOTE_OFF: begin
        strobe_d = 1'b1;
        res_d    = '{out_pitch: rdata_q.pitch, out_velocity: 7'd0, last: 1'b0};
        head_d   = phys_idx(head_q, CNT_W'(1));
        count_d  = count_q - CNT_W'(1);
      end
      DP_NOTE_ON: begin
        wr_en    = 1'b1;
        count_d  = count_q + CNT_W'(1);
        strobe_d = 1'b1;
        res_d    = '{out_pitch: item_q.pitch, out_velocity: item_q.velocity, last: 1'b1};
      end
      DP_TICK_START: begin
        rd_en      = 1'b1;
        rd_idx_d   = CNT_W'(1);
        keep_d     = '0;
        held_vld_d = 1'b0;
      end
      DP_TICK_STEP: begin
        if (tick_dec == '0) begin
          // A due entry is held back so the final one can carry the last flag.
          if (held_vld_q) begin
            strobe_d = 1'b1;
            res_d    = '{out_pitch: held_pitch_q, out_velocity: 7'd0, last: 1'b0};
          end
          held_vld_d   = 1'b1;
          held_pitch_d = rdata_q.pitch;
        end else begin
          wr_en   = 1'b1;
          wr_log  = keep_q;
          wr_data = '{pitch: rdata_q.pitch, ticks: tick_dec};
          keep_d  = keep_q + CNT_W'(1);
        end
        if (rd_idx_q < count_q) begin
          rd_en    = 1'b1;
          rd_log   = rd_idx_q;
          rd_idx_d = rd_idx_q + CNT_W'(1);
        end
      end
      DP_TICK_END: begin
        count_d    = keep_q;
        held_vld_d = 1'b0;
        if (held_vld_q) begin
          strobe_d = 1'b1;
          res_d    = '{out_pitch: held_pitch_q, out_velocity: 7'd0, last: 1'b1};
        end
      end
      DP_STOP_START: begin
        rd_en    = 1'b1;
        rd_log   = count_q - CNT_W'(1);
        rd_idx_d = count_q - CNT_W'(1);
      end
      DP_STOP_STEP: begin
        strobe_d = 1'b1;
        res_d    = '{out_pitch: rdata_q.pitch, out_velocity: 7'd0,
                     last: (rd_idx_q == '0)};
        if (rd_idx_q != '0) begin
          rd_en    = 1'b1;
          rd_log   = rd_idx_q - CNT_W'(1);
          rd_idx_d = rd_idx_q - CNT_W'(1);
        end else begin
          count_d = '0;
        end
      end
      DP_CLEAR: begin
        count_d = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[phys_idx(head_q, wr_log)] <= wr_data;
    end
    if (rd_en) begin
      rdata_q <= mem[phys_idx(head_q, rd_log)];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q    <= '0;
      head_q     <= '0;
      rd_idx_q   <= '0;
      keep_q     <= '0;
      held_vld_q <= 1'b0;
      strobe_q   <= 1'b0;
    end else begin
      count_q    <= count_d;
      head_q     <= head_d;
      rd_idx_q   <= rd_idx_d;
      keep_q     <= keep_d;
      held_vld_q <= held_vld_d;
      strobe_q   <= strobe_d;
    end
  end

  always_ff @(posedge clk_i) begin
    item_q       <= item_d;
    held_pitch_q <= held_pitch_d;
    res_q        <= res_d;
  end

  assign stat_o = '{opcode:   item_q.opcode,
                    vel_zero: (item_q.velocity == 7'd0),
                    full:     (count_q == CNT_W'(MAX_PENDING)),
                    empty:    (count_q == '0),
                    more:     (rd_idx_q < count_q),
                    at_zero:  (rd_idx_q == '0)};
  assign res_o    = res_q;
  assign strobe_o = strobe_q;

endmodule

// ===== rtl/nos_controller.sv =====
// Controller state machine of the note-off scheduler.
// Issues one datapath operation per cycle from datapath status; uses nos_pkg.
module nos_controller (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start_i,
  input  nos_pkg::stat_t stat_i,
  output nos_pkg::cmd_t  cmd_o,
  output logic           busy_o
);
  import nos_pkg::*;

  localparam logic [2:0] S_IDLE     = 3'd0;
  localparam logic [2:0] S_DISPATCH = 3'd1;
  localparam logic [2:0] S_NOTE_OFF = 3'd2;
  localparam logic [2:0] S_NOTE_ON  = 3'd3;
  localparam logic [2:0] S_TICK_RUN = 3'd4;
  localparam logic [2:0] S_TICK_END = 3'd5;
  localparam logic [2:0] S_STOP_RUN = 3'd6;

  logic [2:0] state_q, state_d;
  dp_op_e     op;

  always_comb begin
    state_d = state_q;
    op      = DP_NOP;
    case (state_q)
      S_IDLE: begin
        if (start_i) begin
          op      = DP_CAPTURE;
          state_d = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        case (stat_i.opcode)
          OP_NOTE: begin
            if (stat_i.vel_zero) begin
              state_d = S_IDLE;
            end else if (stat_i.full) begin
              op      = DP_READ_OLDEST;
              state_d = S_NOTE_OFF;
            end else begin
              state_d = S_NOTE_ON;
            end
          end
          OP_TICK: begin
            if (stat_i.empty) begin
              state_d = S_IDLE;
            end else begin
              op      = DP_TICK_START;
              state_d = S_TICK_RUN;
            end
          end
          OP_STOP: begin
            if (stat_i.empty) begin
              state_d = S_IDLE;
            end else begin
              op      = DP_STOP_START;
              state_d = S_STOP_RUN;
            end
          end
          OP_CLEAR: begin
            op      = DP_CLEAR;
            state_d = S_IDLE;
          end
          default: begin
            state_d = S_IDLE;
          end
        endcase
      end
      S_NOTE_OFF: begin
        op      = DP_NOTE_OFF;
        state_d = S_NOTE_ON;
      end
      S_NOTE_ON: begin
        op      = DP_NOTE_ON;
        state_d = S_IDLE;
      end
      S_TICK_RUN: begin
        op = DP_TICK_STEP;
        if (!stat_i.more) begin
          state_d = S_TICK_END;
        end
      end
      S_TICK_END: begin
        op      = DP_TICK_END;
        state_d = S_IDLE;
      end
      S_STOP_RUN: begin
        op = DP_STOP_STEP;
        if (stat_i.at_zero) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign cmd_o  = '{op: op};
  assign busy_o = (state_q != S_IDLE);

endmodule

// ===== rtl/note_off_scheduler_top.sv =====
// Note-off scheduler: pairs each note-on with a note-off after a tick count.
// Top level joining nos_controller and nos_datapath; uses nos_pkg.
//
// Usage: drive an item on in_i and raise start; it is taken at a rising edge
// where start is high and busy is low. Note items with nonzero velocity give
// a note-on, preceded by the note-off of the oldest pending note when all
// MAX_PENDING entries are in use. Tick items count every pending note down
// and give note-offs, oldest first, for those that reach zero. Stop items give
// note-offs for all pending notes, newest first. Clear items drop them quietly.
// Each result appears on res_o for exactly one cycle with strobe_o high; the
// last flag marks the final result of an item. Results cannot be held off.
// Timing: busy rises the cycle after a transfer. Tick and stop items read
// one pending entry per cycle from the pending-entry memory; a zero-velocity
// note, a clear, and a tick or stop on an empty table go from dispatch
// straight back to idle.
// Results lag their datapath step by one register.
// Reset empties the pending table; no clearing pass is needed.
module note_off_scheduler_top (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             start,
  input  nos_pkg::item_t   in_i,
  output logic             busy,
  output nos_pkg::result_t res_o,
  output logic             strobe_o
);
  import nos_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  nos_controller u_ctrl (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (start),
    .stat_i  (stat),
    .cmd_o   (cmd),
    .busy_o  (busy)
  );

  nos_datapath u_dp (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .item_i   (in_i),
    .cmd_i    (cmd),
    .stat_o   (stat),
    .res_o    (res_o),
    .strobe_o (strobe_o)
  );

endmodule

// ===== rtl/nos_checker.sv =====
// Port-level checker for the note-off scheduler and its bind to the top.
// Depends on nos_pkg and note_off_scheduler_top_macros.svh.
`include "note_off_scheduler_top_macros.svh"

module nos_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             start,
  input logic             busy,
  input nos_pkg::result_t res_o,
  input logic             strobe_o
);
  import nos_pkg::*;

  logic transfer;
  logic res_last;

  assign transfer = start && !busy;
  assign res_last = res_o.last;

  // Every transfer is followed by a dispatch cycle.
  `NOS_ASSERT_NEXT(a_busy_after_transfer, clk_i, rst_ni, transfer, busy)
  // The dispatch cycle never carries a result.
  `NOS_ASSERT_NEXT(a_no_result_after_transfer, clk_i, rst_ni, transfer, !strobe_o)
  // An idle block with no transfer produces nothing in the next cycle.
  `NOS_ASSERT_NEXT(a_quiet_when_idle, clk_i, rst_ni, !busy && !start, !strobe_o)
  // A result only appears while busy or just after the item finished.
  `NOS_ASSERT_SAME(a_result_while_working, clk_i, rst_ni, strobe_o, $past(busy))
  // Once the block is idle after a result, that result closed its item.
  `NOS_ASSERT_SAME(a_idle_result_is_last, clk_i, rst_ni, strobe_o && !busy, res_last)

endmodule

bind note_off_scheduler_top nos_checker u_nos_checker (
  .clk_i    (clk_i),
  .rst_ni   (rst_ni),
  .start    (start),
  .busy     (busy),
  .res_o    (res_o),
  .strobe_o (strobe_o)
);
